// File: src/pcr_pkg.sv
// Shared types and constants for the page cache replacement policy block.
// No dependencies; imported by every other file in src.
package pcr_pkg;

   // Register field widths of the configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int POLICY_W   = 2;
   localparam int EIU_W      = 3;
   localparam int LAT_W      = 8;

   // Result field widths
   localparam int SLOT_OUT_W = 2;
   localparam int PAGE_NUM_W = 8;
   localparam int PAGE_OFF_W = 12;

   // Reset values of the registers
   localparam logic [EIU_W-1:0] EIU_RESET      = 3'd4;
   localparam logic [LAT_W-1:0] HIT_LAT_RESET  = 8'd1;
   localparam logic [LAT_W-1:0] MISS_LAT_RESET = 8'd100;

   typedef enum logic [POLICY_W-1:0] {
      POL_FIFO = 2'd0,
      POL_LRU  = 2'd1,
      POL_MRU  = 2'd2,
      POL_NONE = 2'd3
   } pcr_policy_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLICY   = 2'd0,
      CSR_ENTRIES  = 2'd1,
      CSR_HIT_LAT  = 2'd2,
      CSR_MISS_LAT = 2'd3
   } pcr_csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } pcr_state_type;

   typedef struct packed {
      pcr_policy_type   policy;
      logic [EIU_W-1:0] entries_in_use;
      logic [LAT_W-1:0] hit_latency;
      logic [LAT_W-1:0] miss_latency;
   } pcr_cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch address, restart scan
      logic scan;      // examine one slot
      logic commit;    // apply outcome, load result registers
   } pcr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_last;
   } pcr_status_type;

endpackage

// File: src/pcr_ctrl.sv
// Transaction sequencer for the page cache replacement policy block.
// Depends on pcr_pkg for the state, command and status types.
module pcr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output pcr_pkg::pcr_cmd_type    cmd,
   input  pcr_pkg::pcr_status_type status
);
   import pcr_pkg::*;

   pcr_state_type state_ff;
   pcr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // result on the ports this cycle; next transaction may start now
            busy      = 1'b0;
            rsp_valid = 1'b1;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

endmodule

// File: src/pcr_dpath.sv
// Slot store, scan registers, victim selection and recency update.
// Depends on pcr_pkg for configuration, command and status types.
module pcr_dpath #(
   parameter int ENTRIES   = 4,
   parameter int PAGE_SIZE = 4096,
   parameter int ADDR_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pcr_pkg::pcr_cfg_type                 cfg,
   input  pcr_pkg::pcr_cmd_type                 cmd,
   output pcr_pkg::pcr_status_type              status,
   input  logic [ADDR_BITS-1:0]                 address,
   output logic                                 hit,
   output logic [pcr_pkg::SLOT_OUT_W-1:0]       slot,
   output logic                                 filled,
   output logic                                 evicted,
   output logic [pcr_pkg::PAGE_NUM_W-1:0]       page_number,
   output logic [pcr_pkg::PAGE_OFF_W-1:0]       page_offset,
   output logic [pcr_pkg::LAT_W-1:0]            access_latency
);
   import pcr_pkg::*;

   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int OFF_W  = $clog2(PAGE_SIZE);
   localparam int TAG_W  = (ADDR_BITS > OFF_W) ? (ADDR_BITS - OFF_W) : 1;
   localparam logic [ADDR_BITS-1:0] OFF_MASK = ADDR_BITS'(PAGE_SIZE - 1);

   // Slot state
   logic              valid_ff [ENTRIES];
   logic              valid_in [ENTRIES];
   logic [TAG_W-1:0]  tag_ff   [ENTRIES];
   logic [SLOT_W-1:0] rank_ff  [ENTRIES];
   logic [SLOT_W-1:0] rank_in  [ENTRIES];
   logic [SLOT_W-1:0] fifo_ptr_ff, fifo_ptr_in;
   logic [SLOT_W-1:0] mru_ff, mru_in;

   // Per-transaction registers
   logic [ADDR_BITS-1:0] addr_ff;
   logic [SLOT_W-1:0]    idx_ff;
   logic                 found_ff;
   logic [SLOT_W-1:0]    hit_slot_ff;
   logic                 free_ff;
   logic [SLOT_W-1:0]    free_slot_ff;
   logic [SLOT_W-1:0]    best_slot_ff;
   logic [SLOT_W-1:0]    best_rank_ff;

   // Result registers
   logic                  hit_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic                  filled_ff;
   logic                  evicted_ff;
   logic [ADDR_BITS-1:0]  page_full_ff;
   logic [ADDR_BITS-1:0]  offset_full_ff;
   logic [LAT_W-1:0]      lat_ff;

   logic [CNT_W-1:0]     n_act;
   logic [ADDR_BITS-1:0] page_full;
   logic [TAG_W-1:0]     page_tag;
   logic                 cur_valid;
   logic [TAG_W-1:0]     cur_tag;
   logic [SLOT_W-1:0]    cur_rank;

   logic                 do_touch;
   logic                 do_fill;
   logic                 do_evict;
   logic                 was_valid;
   logic [SLOT_W-1:0]    sel_slot;
   logic [SLOT_W-1:0]    sel_rank;
   logic [SLOT_W-1:0]    fifo_slot;
   logic                 fifo_adv;

   // Active slot count: zero acts as one, clamp to the built count
   always_comb begin
      if (cfg.entries_in_use == '0) begin
         n_act = CNT_W'(1);
      end else if (32'(cfg.entries_in_use) > ENTRIES) begin
         n_act = CNT_W'(ENTRIES);
      end else begin
         n_act = CNT_W'(cfg.entries_in_use);
      end
   end

   assign page_full = addr_ff >> OFF_W;
   assign page_tag  = TAG_W'(page_full);

   assign cur_valid = valid_ff[idx_ff];
   assign cur_tag   = tag_ff[idx_ff];
   assign cur_rank  = rank_ff[idx_ff];

   assign status.scan_last = (CNT_W'(idx_ff) == (n_act - CNT_W'(1)));

   // Scan: one slot per cycle, first match, first free slot, oldest slot
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff      <= address;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         hit_slot_ff  <= '0;
         free_ff      <= 1'b0;
         free_slot_ff <= '0;
         best_slot_ff <= '0;
         best_rank_ff <= '0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + SLOT_W'(1);
         if (cur_valid && (cur_tag == page_tag) && !found_ff) begin
            found_ff    <= 1'b1;
            hit_slot_ff <= idx_ff;
         end
         if (!cur_valid && !free_ff) begin
            free_ff      <= 1'b1;
            free_slot_ff <= idx_ff;
         end
         // strict compare keeps the lowest slot among equally old ones
         if (cur_rank > best_rank_ff) begin
            best_slot_ff <= idx_ff;
            best_rank_ff <= cur_rank;
         end
      end
   end

   // Outcome of the transaction
   always_comb begin
      fifo_slot = (CNT_W'(fifo_ptr_ff) < n_act) ? fifo_ptr_ff : '0;
      do_touch  = 1'b0;
      do_fill   = 1'b0;
      do_evict  = 1'b0;
      was_valid = 1'b1;
      sel_slot  = '0;
      fifo_adv  = 1'b0;
      if (found_ff) begin
         do_touch = 1'b1;
         sel_slot = hit_slot_ff;
      end else if (free_ff) begin
         do_touch  = 1'b1;
         do_fill   = 1'b1;
         was_valid = 1'b0;
         sel_slot  = free_slot_ff;
      end else begin
         case (cfg.policy)
            POL_FIFO: begin
               sel_slot = fifo_slot;
               fifo_adv = 1'b1;
            end
            POL_LRU: begin
               sel_slot = best_slot_ff;
            end
            POL_MRU: begin
               sel_slot = (CNT_W'(mru_ff) < n_act) ? mru_ff : '0;
            end
            default: begin
               sel_slot = '0;
            end
         endcase
         if (cfg.policy != POL_NONE) begin
            do_touch = 1'b1;
            do_fill  = 1'b1;
            do_evict = 1'b1;
         end
      end
   end

   assign sel_rank = rank_ff[sel_slot];

   // Recency update: younger slots age by one, all on a free-slot fill
   always_comb begin
      fifo_ptr_in = fifo_ptr_ff;
      mru_in      = mru_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
      end
      if (cmd.commit && do_touch) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if ((SLOT_W'(i) != sel_slot) && (CNT_W'(i) < n_act) && valid_ff[i] &&
                (!was_valid || (rank_ff[i] < sel_rank))) begin
               rank_in[i] = rank_ff[i] + SLOT_W'(1);
            end
            if (SLOT_W'(i) == sel_slot) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
            end
         end
         mru_in = sel_slot;
         if (fifo_adv) begin
            fifo_ptr_in = ((CNT_W'(fifo_slot) + CNT_W'(1)) == n_act) ?
                          '0 : fifo_slot + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
         fifo_ptr_ff <= '0;
         mru_ff      <= '0;
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
            rank_ff[i]  <= rank_in[i];
         end
         fifo_ptr_ff <= fifo_ptr_in;
         mru_ff      <= mru_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_fill) begin
         tag_ff[sel_slot] <= page_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff         <= found_ff;
         slot_ff        <= sel_slot;
         filled_ff      <= do_fill;
         evicted_ff     <= do_evict;
         page_full_ff   <= page_full;
         offset_full_ff <= addr_ff & OFF_MASK;
         lat_ff         <= found_ff ? cfg.hit_latency : cfg.miss_latency;
      end
   end

   assign hit            = hit_ff;
   assign slot           = SLOT_OUT_W'(slot_ff);
   assign filled         = filled_ff;
   assign evicted        = evicted_ff;
   assign page_number    = PAGE_NUM_W'(page_full_ff);
   assign page_offset    = PAGE_OFF_W'(offset_full_ff);
   assign access_latency = lat_ff;

endmodule

// File: src/page_cache_replacement_policy.sv
// Top level of the page cache replacement policy block: register file and
// integration of pcr_ctrl and pcr_dpath. Depends on pcr_pkg.
//
// Usage:
//   Request: drive req_address and raise start while busy is low;
//   the transaction is taken at that clock edge.
//   Result: rsp_valid is high for exactly one cycle with hit, slot, filled,
//   evicted, page number, offset and latency on the rsp_ ports. The
//   receiver cannot stall; the result must be taken in that cycle.
//   Sequence: the tag scan examines one slot per cycle over the first N
//   slots, where N is the active slot count (entries_in_use clamped to
//   1..ENTRIES); then the update state applies the outcome and loads the
//   result registers, and the done state then raises rsp_valid.
//   A new request can be accepted in the cycle the result is shown.
//   Registers: csr_ready is always high; write with csr_valid, csr_index and
//   csr_wdata, only while no transaction is outstanding.
//   Reset: synchronous, active high; empties the cache, clears recency
//   ranks and pointers, and restores register defaults.
module page_cache_replacement_policy #(
   parameter int ENTRIES   = 4,
   parameter int PAGE_SIZE = 4096,
   parameter int ADDR_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ADDR_BITS-1:0]                req_address,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [pcr_pkg::SLOT_OUT_W-1:0]      rsp_slot,
   output logic                                rsp_filled,
   output logic                                rsp_evicted,
   output logic [pcr_pkg::PAGE_NUM_W-1:0]      rsp_page_number,
   output logic [pcr_pkg::PAGE_OFF_W-1:0]      rsp_page_offset,
   output logic [pcr_pkg::LAT_W-1:0]           rsp_access_latency,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pcr_pkg::*;

   pcr_cfg_type    cfg_ff;
   pcr_cfg_type    cfg_in;
   pcr_cmd_type    cmd;
   pcr_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (pcr_csr_idx_type'(csr_index))
            CSR_POLICY:   cfg_in.policy         = pcr_policy_type'(csr_wdata[POLICY_W-1:0]);
            CSR_ENTRIES:  cfg_in.entries_in_use = csr_wdata[EIU_W-1:0];
            CSR_HIT_LAT:  cfg_in.hit_latency    = csr_wdata[LAT_W-1:0];
            CSR_MISS_LAT: cfg_in.miss_latency   = csr_wdata[LAT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy         <= POL_FIFO;
         cfg_ff.entries_in_use <= EIU_RESET;
         cfg_ff.hit_latency    <= HIT_LAT_RESET;
         cfg_ff.miss_latency   <= MISS_LAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   pcr_dpath #(
      .ENTRIES   (ENTRIES),
      .PAGE_SIZE (PAGE_SIZE),
      .ADDR_BITS (ADDR_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .address         (req_address),
      .hit             (rsp_hit),
      .slot            (rsp_slot),
      .filled          (rsp_filled),
      .evicted         (rsp_evicted),
      .page_number     (rsp_page_number),
      .page_offset     (rsp_page_offset),
      .access_latency  (rsp_access_latency)
   );

endmodule
